@@ rtl/byte_cpu_alu_register_execute_top_defines.svh @@
// Assertion macros for the byte CPU execute block.
// Used by byte_cpu_alu_register_execute_top; no other dependencies.
`ifndef BYTE_CPU_ALU_REGISTER_EXECUTE_TOP_DEFINES_SVH
`define BYTE_CPU_ALU_REGISTER_EXECUTE_TOP_DEFINES_SVH

// same-cycle implication
`define BCPU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BCPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bcpu_pkg.sv @@
// Shared types, constants and helper functions for the byte CPU execute block.
// No dependencies.
package bcpu_pkg;

   typedef enum logic [5:0] {
      FN_ADC, FN_AND, FN_ASL, FN_BCC, FN_BCS, FN_BEQ, FN_BIT, FN_BMI, FN_BNE, FN_BPL,
      FN_BVC, FN_BVS, FN_CLC, FN_CLD, FN_CLI, FN_CLV, FN_CMP, FN_CPX, FN_CPY, FN_DEC,
      FN_DEX, FN_DEY, FN_EOR, FN_INC, FN_INX, FN_INY, FN_LDA, FN_LDX, FN_LDY, FN_LSR,
      FN_NOP, FN_ORA, FN_ROL, FN_ROR, FN_SBC, FN_SEC, FN_SED, FN_SEI, FN_STA, FN_STX,
      FN_STY, FN_TAX, FN_TAY, FN_TSX, FN_TXA, FN_TXS, FN_TYA, FN_ALR, FN_ANC, FN_ARR,
      FN_AXS, FN_DCP, FN_ISC, FN_KIL, FN_LAS, FN_LAX, FN_RLA, FN_RRA, FN_SAX, FN_SLO,
      FN_SRE, FN_TAS, FN_XAA
   } func_type;

   typedef enum logic [1:0] {SH_ASL, SH_LSR, SH_ROL, SH_ROR} shift_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } regs_type;

   localparam logic [2:0] FLAG_C = 3'd0;
   localparam logic [2:0] FLAG_Z = 3'd1;
   localparam logic [2:0] FLAG_I = 3'd2;
   localparam logic [2:0] FLAG_D = 3'd3;
   localparam logic [2:0] FLAG_B = 3'd4;
   localparam logic [2:0] FLAG_U = 3'd5;
   localparam logic [2:0] FLAG_V = 3'd6;
   localparam logic [2:0] FLAG_N = 3'd7;

   localparam logic [7:0] SP_RESET     = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r         = p;
      r[FLAG_Z] = (v == 8'h00);
      r[FLAG_N] = v[7];
      return r;
   endfunction

   // {carry_out, result}
   function automatic logic [8:0] shift_fn(input shift_type kind, input logic [7:0] v,
                                           input logic cin);
      logic [8:0] r;
      case (kind)
         SH_ASL:  r = {v[7], v[6:0], 1'b0};
         SH_LSR:  r = {v[0], 1'b0, v[7:1]};
         SH_ROL:  r = {v[7], v[6:0], cin};
         SH_ROR:  r = {v[0], cin, v[7:1]};
         default: r = {v[0], cin, v[7:1]};
      endcase
      return r;
   endfunction

endpackage

@@ rtl/bcpu_alu.sv @@
// Combinational ALU and register update for one decoded operation.
// Depends on bcpu_pkg.
module bcpu_alu
   import bcpu_pkg::*;
(
   input  regs_type   cur,
   input  logic [5:0] func,
   input  logic [7:0] operand,
   input  logic       to_accumulator,
   output regs_type   nxt,
   output logic       mem_write_en,
   output logic [7:0] mem_write_data,
   output logic       branch_taken
);

   func_type   fn;
   shift_type  sh_kind;
   logic [7:0] sh_src;
   logic [8:0] sh_res;
   logic [7:0] op_inc;
   logic [7:0] op_dec;
   logic [7:0] add_m;
   logic [8:0] add_sum;
   logic       add_v;
   logic [7:0] cmp_reg;
   logic [7:0] cmp_m;
   logic [8:0] cmp_diff;
   logic [7:0] and_op;
   logic [7:0] and_ax;

   assign fn     = func_type'(func);
   assign op_inc = operand + 8'd1;
   assign op_dec = operand - 8'd1;
   assign and_op = cur.acc & operand;
   assign and_ax = cur.acc & cur.x;

   always_comb begin
      case (fn)
         FN_ASL, FN_SLO:         sh_kind = SH_ASL;
         FN_LSR, FN_SRE, FN_ALR: sh_kind = SH_LSR;
         FN_ROL, FN_RLA:         sh_kind = SH_ROL;
         default:                sh_kind = SH_ROR;
      endcase
      case (fn)
         FN_ALR, FN_ARR:                 sh_src = and_op;
         FN_ASL, FN_LSR, FN_ROL, FN_ROR: sh_src = to_accumulator ? cur.acc : operand;
         default:                        sh_src = operand;
      endcase
   end

   assign sh_res = shift_fn(sh_kind, sh_src, cur.p[FLAG_C]);

   always_comb begin
      case (fn)
         FN_SBC:  add_m = ~operand;
         FN_ISC:  add_m = ~op_inc;
         FN_RRA:  add_m = sh_res[7:0];
         default: add_m = operand;
      endcase
   end

   // RRA adds with the carry left by its rotate
   assign add_sum = {1'b0, cur.acc} + {1'b0, add_m}
                  + {8'h00, (fn == FN_RRA) ? sh_res[8] : cur.p[FLAG_C]};
   assign add_v   = (cur.acc[7] ^ add_sum[7]) & (add_m[7] ^ add_sum[7]);

   always_comb begin
      case (fn)
         FN_CPX:  cmp_reg = cur.x;
         FN_CPY:  cmp_reg = cur.y;
         FN_AXS:  cmp_reg = and_ax;
         default: cmp_reg = cur.acc;
      endcase
   end

   assign cmp_m    = (fn == FN_DCP) ? op_dec : operand;
   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

   always_comb begin
      nxt            = cur;
      mem_write_en   = 1'b0;
      mem_write_data = 8'h00;
      branch_taken   = 1'b0;
      case (fn)
         FN_ADC, FN_SBC, FN_ISC, FN_RRA: begin
            nxt.acc         = add_sum[7:0];
            nxt.p[FLAG_C]   = add_sum[8];
            nxt.p[FLAG_V]   = add_v;
            nxt.p           = set_nz(nxt.p, add_sum[7:0]);
            if (fn == FN_ISC) begin
               mem_write_en   = 1'b1;
               mem_write_data = op_inc;
            end else if (fn == FN_RRA) begin
               mem_write_en   = 1'b1;
               mem_write_data = sh_res[7:0];
            end
         end
         FN_AND: begin
            nxt.acc = and_op;
            nxt.p   = set_nz(cur.p, and_op);
         end
         FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
            nxt.p         = set_nz(cur.p, sh_res[7:0]);
            nxt.p[FLAG_C] = sh_res[8];
            if (to_accumulator) begin
               nxt.acc = sh_res[7:0];
            end else begin
               mem_write_en   = 1'b1;
               mem_write_data = sh_res[7:0];
            end
         end
         FN_BCC: branch_taken = ~cur.p[FLAG_C];
         FN_BCS: branch_taken =  cur.p[FLAG_C];
         FN_BEQ: branch_taken =  cur.p[FLAG_Z];
         FN_BNE: branch_taken = ~cur.p[FLAG_Z];
         FN_BMI: branch_taken =  cur.p[FLAG_N];
         FN_BPL: branch_taken = ~cur.p[FLAG_N];
         FN_BVS: branch_taken =  cur.p[FLAG_V];
         FN_BVC: branch_taken = ~cur.p[FLAG_V];
         FN_BIT: begin
            nxt.p[FLAG_Z] = (and_op == 8'h00);
            nxt.p[FLAG_N] = operand[7];
            nxt.p[FLAG_V] = operand[6];
         end
         FN_CLC: nxt.p[FLAG_C] = 1'b0;
         FN_CLD: nxt.p[FLAG_D] = 1'b0;
         FN_CLI: nxt.p[FLAG_I] = 1'b0;
         FN_CLV: nxt.p[FLAG_V] = 1'b0;
         FN_SEC: nxt.p[FLAG_C] = 1'b1;
         FN_SED: nxt.p[FLAG_D] = 1'b1;
         FN_SEI: nxt.p[FLAG_I] = 1'b1;
         FN_CMP, FN_CPX, FN_CPY, FN_DCP, FN_AXS: begin
            nxt.p         = set_nz(cur.p, cmp_diff[7:0]);
            nxt.p[FLAG_C] = ~cmp_diff[8];
            if (fn == FN_DCP) begin
               mem_write_en   = 1'b1;
               mem_write_data = op_dec;
            end
            if (fn == FN_AXS) begin
               nxt.x = cmp_diff[7:0];
            end
         end
         FN_DEC: begin
            mem_write_en   = 1'b1;
            mem_write_data = op_dec;
            nxt.p          = set_nz(cur.p, op_dec);
         end
         FN_INC: begin
            mem_write_en   = 1'b1;
            mem_write_data = op_inc;
            nxt.p          = set_nz(cur.p, op_inc);
         end
         FN_DEX: begin
            nxt.x = cur.x - 8'd1;
            nxt.p = set_nz(cur.p, nxt.x);
         end
         FN_DEY: begin
            nxt.y = cur.y - 8'd1;
            nxt.p = set_nz(cur.p, nxt.y);
         end
         FN_INX: begin
            nxt.x = cur.x + 8'd1;
            nxt.p = set_nz(cur.p, nxt.x);
         end
         FN_INY: begin
            nxt.y = cur.y + 8'd1;
            nxt.p = set_nz(cur.p, nxt.y);
         end
         FN_EOR: begin
            nxt.acc = cur.acc ^ operand;
            nxt.p   = set_nz(cur.p, nxt.acc);
         end
         FN_ORA: begin
            nxt.acc = cur.acc | operand;
            nxt.p   = set_nz(cur.p, nxt.acc);
         end
         FN_LDA: begin
            nxt.acc = operand;
            nxt.p   = set_nz(cur.p, operand);
         end
         FN_LDX: begin
            nxt.x = operand;
            nxt.p = set_nz(cur.p, operand);
         end
         FN_LDY: begin
            nxt.y = operand;
            nxt.p = set_nz(cur.p, operand);
         end
         FN_STA: begin
            mem_write_en   = 1'b1;
            mem_write_data = cur.acc;
         end
         FN_STX: begin
            mem_write_en   = 1'b1;
            mem_write_data = cur.x;
         end
         FN_STY: begin
            mem_write_en   = 1'b1;
            mem_write_data = cur.y;
         end
         FN_TAX: begin
            nxt.x = cur.acc;
            nxt.p = set_nz(cur.p, cur.acc);
         end
         FN_TAY: begin
            nxt.y = cur.acc;
            nxt.p = set_nz(cur.p, cur.acc);
         end
         FN_TSX: begin
            nxt.x = cur.sp;
            nxt.p = set_nz(cur.p, cur.sp);
         end
         FN_TXA: begin
            nxt.acc = cur.x;
            nxt.p   = set_nz(cur.p, cur.x);
         end
         FN_TYA: begin
            nxt.acc = cur.y;
            nxt.p   = set_nz(cur.p, cur.y);
         end
         FN_TXS: nxt.sp = cur.x;
         FN_ALR, FN_ARR: begin
            nxt.acc       = sh_res[7:0];
            nxt.p         = set_nz(cur.p, sh_res[7:0]);
            nxt.p[FLAG_C] = sh_res[8];
         end
         FN_ANC: begin
            nxt.acc       = and_op;
            nxt.p         = set_nz(cur.p, and_op);
            nxt.p[FLAG_C] = and_op[7];
         end
         FN_LAS: begin
            nxt.sp  = cur.sp & operand;
            nxt.acc = nxt.sp;
            nxt.x   = nxt.sp;
            nxt.p   = set_nz(cur.p, nxt.sp);
         end
         FN_LAX: begin
            nxt.acc = operand;
            nxt.x   = operand;
            nxt.p   = set_nz(cur.p, operand);
         end
         FN_RLA, FN_SLO, FN_SRE: begin
            mem_write_en   = 1'b1;
            mem_write_data = sh_res[7:0];
            if (fn == FN_RLA) begin
               nxt.acc = cur.acc & sh_res[7:0];
            end else if (fn == FN_SLO) begin
               nxt.acc = cur.acc | sh_res[7:0];
            end else begin
               nxt.acc = cur.acc ^ sh_res[7:0];
            end
            nxt.p         = set_nz(cur.p, nxt.acc);
            nxt.p[FLAG_C] = sh_res[8];
         end
         FN_SAX: begin
            mem_write_en   = 1'b1;
            mem_write_data = and_ax;
         end
         FN_TAS: nxt.sp = and_ax;
         FN_XAA: begin
            nxt.acc = cur.x & operand;
            nxt.p   = set_nz(cur.p, nxt.acc);
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/byte_cpu_alu_register_execute_top.sv @@
// Result: an accepted beat is registered and appears on rsp_ in the next cycle.
// Throughput: one beat per cycle unless a stall on rsp_ holds req_; req_ready =
// !rsp_valid | rsp_ready, so the single result register is the only buffering.
// The next beat sees the registers left by the previous one without delay.
// Reset (synchronous, high): A = X = Y = 0, SP = 0xFD, P = 0x24, no result held.
// Depends on bcpu_pkg, bcpu_alu and byte_cpu_alu_register_execute_top_defines.svh.
`include "byte_cpu_alu_register_execute_top_defines.svh"

module byte_cpu_alu_register_execute_top
   import bcpu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [5:0] req_func,
   input  logic [7:0] req_operand,
   input  logic       req_to_accumulator,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_acc,
   output logic [7:0] rsp_index_x,
   output logic [7:0] rsp_index_y,
   output logic [7:0] rsp_stack_ptr,
   output logic [7:0] rsp_flags,
   output logic       rsp_mem_write_en,
   output logic [7:0] rsp_mem_write_data,
   output logic       rsp_branch_taken
);

   regs_type   regs_ff;
   regs_type   regs_in;
   logic       rsp_valid_ff;
   logic       we_ff;
   logic       we_in;
   logic [7:0] wd_ff;
   logic [7:0] wd_in;
   logic       br_ff;
   logic       br_in;
   logic       accept;

   bcpu_alu u_alu (
      .cur            (regs_ff),
      .func           (req_func),
      .operand        (req_operand),
      .to_accumulator (req_to_accumulator),
      .nxt            (regs_in),
      .mem_write_en   (we_in),
      .mem_write_data (wd_in),
      .branch_taken   (br_in)
   );

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.acc  <= 8'h00;
         regs_ff.x    <= 8'h00;
         regs_ff.y    <= 8'h00;
         regs_ff.sp   <= SP_RESET;
         regs_ff.p    <= STATUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            regs_ff      <= regs_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         we_ff <= we_in;
         wd_ff <= wd_in;
         br_ff <= br_in;
      end
   end

   // architectural registers only change on accept, so they are the result
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_acc            = regs_ff.acc;
   assign rsp_index_x        = regs_ff.x;
   assign rsp_index_y        = regs_ff.y;
   assign rsp_stack_ptr      = regs_ff.sp;
   assign rsp_flags          = regs_ff.p;
   assign rsp_mem_write_en   = we_ff;
   assign rsp_mem_write_data = wd_ff;
   assign rsp_branch_taken   = br_ff;

   `BCPU_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid, "accepted beat lost")
   `BCPU_ASSERT_NOW(a_wd_zero, clock, reset, rsp_valid && !rsp_mem_write_en, rsp_mem_write_data == 8'h00, "write data without enable")
   `BCPU_ASSERT_NOW(a_branch_no_write, clock, reset, rsp_valid && rsp_branch_taken, !rsp_mem_write_en, "branch with memory write")
   `BCPU_ASSERT_NOW(a_fixed_flags, clock, reset, rsp_valid, rsp_flags[FLAG_U] && !rsp_flags[FLAG_B], "fixed status bits changed")

endmodule

@@ dv/byte_cpu_alu_register_execute_top_test.sv @@
// Self-checking testbench for byte_cpu_alu_register_execute_top: directed and random
// operations with randomized stalls on both channels, checked against a local model.
// Depends on bcpu_pkg and the RTL of the execute block.
`timescale 1ns / 100ps

module byte_cpu_alu_register_execute_top_test;
   import bcpu_pkg::*;

   localparam logic [5:0] FN_UNUSED   = 6'd63;
   localparam int         CYCLE_LIMIT = 100000;
   localparam int         LONG_STALL  = 150;
   localparam int         RANDOM_OPS  = 190;

   typedef struct packed {
      logic [5:0] func;
      logic [7:0] operand;
      logic       to_acc;
   } exec_req_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] flags;
      logic       we;
      logic [7:0] wd;
      logic       br;
   } exec_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [5:0] req_func = '0;
   logic [7:0] req_operand = '0;
   logic       req_to_accumulator = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_acc;
   logic [7:0] rsp_index_x;
   logic [7:0] rsp_index_y;
   logic [7:0] rsp_stack_ptr;
   logic [7:0] rsp_flags;
   logic       rsp_mem_write_en;
   logic [7:0] rsp_mem_write_data;
   logic       rsp_branch_taken;

   exec_req_type ops_to_issue[$];
   exec_rsp_type regs_expected[$];
   int        items_queued = 0;
   int        items_accepted = 0;
   int        mismatches = 0;
   int        send_idle = 0;
   int        recv_idle = 0;
   logic      req_took = 1'b0;
   logic      stall_go = 1'b0;
   logic      stall_done = 1'b0;
   int        stall_left = 0;

   // architectural state of the model
   logic [7:0] pred_a, pred_x, pred_y, pred_sp, pred_p;

   byte_cpu_alu_register_execute_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_operand        (req_operand),
      .req_to_accumulator (req_to_accumulator),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_acc            (rsp_acc),
      .rsp_index_x        (rsp_index_x),
      .rsp_index_y        (rsp_index_y),
      .rsp_stack_ptr      (rsp_stack_ptr),
      .rsp_flags          (rsp_flags),
      .rsp_mem_write_en   (rsp_mem_write_en),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_branch_taken   (rsp_branch_taken)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void flag_nz(input logic [7:0] v);
      pred_p[FLAG_Z] = (v == 8'h00);
      pred_p[FLAG_N] = v[7];
   endfunction

   function automatic void add_carry(input logic [7:0] m);
      logic [8:0] s;
      s = {1'b0, pred_a} + {1'b0, m} + {8'h00, pred_p[FLAG_C]};
      pred_p[FLAG_C] = s[8];
      pred_p[FLAG_V] = (pred_a[7] ^ s[7]) & (m[7] ^ s[7]);
      pred_a = s[7:0];
      flag_nz(pred_a);
   endfunction

   function automatic void compare_to(input logic [7:0] r, input logic [7:0] m);
      logic [7:0] d;
      d = r - m;
      pred_p[FLAG_C] = (r >= m);
      flag_nz(d);
   endfunction

   function automatic logic [7:0] shift_rot(input shift_type kind, input logic [7:0] v);
      logic [7:0] r;
      logic       cin;
      logic       cout;
      cin = pred_p[FLAG_C];
      case (kind)
         SH_ASL: begin
            r = {v[6:0], 1'b0};
            cout = v[7];
         end
         SH_LSR: begin
            r = {1'b0, v[7:1]};
            cout = v[0];
         end
         SH_ROL: begin
            r = {v[6:0], cin};
            cout = v[7];
         end
         default: begin
            r = {cin, v[7:1]};
            cout = v[0];
         end
      endcase
      pred_p[FLAG_C] = cout;
      flag_nz(r);
      return r;
   endfunction

   function automatic exec_rsp_type execute_op(input exec_req_type it);
      exec_rsp_type res;
      shift_type  kind;
      logic [7:0] opd;
      logic [7:0] t;
      logic [7:0] ax;
      logic       we;
      logic [7:0] wd;
      logic       br;
      opd = it.operand;
      we = 1'b0;
      wd = 8'h00;
      br = 1'b0;
      case (it.func)
         FN_ADC: add_carry(opd);
         FN_AND: begin
            pred_a = pred_a & opd;
            flag_nz(pred_a);
         end
         FN_ASL, FN_LSR, FN_ROL, FN_ROR: begin
            kind = (it.func == FN_ASL) ? SH_ASL : (it.func == FN_LSR) ? SH_LSR :
                   (it.func == FN_ROL) ? SH_ROL : SH_ROR;
            t = shift_rot(kind, it.to_acc ? pred_a : opd);
            if (it.to_acc) begin
               pred_a = t;
            end else begin
               we = 1'b1;
               wd = t;
            end
         end
         FN_BCC: br = !pred_p[FLAG_C];
         FN_BCS: br = pred_p[FLAG_C];
         FN_BEQ: br = pred_p[FLAG_Z];
         FN_BMI: br = pred_p[FLAG_N];
         FN_BNE: br = !pred_p[FLAG_Z];
         FN_BPL: br = !pred_p[FLAG_N];
         FN_BVC: br = !pred_p[FLAG_V];
         FN_BVS: br = pred_p[FLAG_V];
         FN_BIT: begin
            pred_p[FLAG_Z] = ((pred_a & opd) == 8'h00);
            pred_p[FLAG_N] = opd[7];
            pred_p[FLAG_V] = opd[6];
         end
         FN_CLC: pred_p[FLAG_C] = 1'b0;
         FN_CLD: pred_p[FLAG_D] = 1'b0;
         FN_CLI: pred_p[FLAG_I] = 1'b0;
         FN_CLV: pred_p[FLAG_V] = 1'b0;
         FN_SEC: pred_p[FLAG_C] = 1'b1;
         FN_SED: pred_p[FLAG_D] = 1'b1;
         FN_SEI: pred_p[FLAG_I] = 1'b1;
         FN_CMP: compare_to(pred_a, opd);
         FN_CPX: compare_to(pred_x, opd);
         FN_CPY: compare_to(pred_y, opd);
         FN_DEC: begin
            we = 1'b1;
            wd = opd - 8'd1;
            flag_nz(wd);
         end
         FN_INC: begin
            we = 1'b1;
            wd = opd + 8'd1;
            flag_nz(wd);
         end
         FN_DEX: begin
            pred_x = pred_x - 8'd1;
            flag_nz(pred_x);
         end
         FN_DEY: begin
            pred_y = pred_y - 8'd1;
            flag_nz(pred_y);
         end
         FN_INX: begin
            pred_x = pred_x + 8'd1;
            flag_nz(pred_x);
         end
         FN_INY: begin
            pred_y = pred_y + 8'd1;
            flag_nz(pred_y);
         end
         FN_EOR: begin
            pred_a = pred_a ^ opd;
            flag_nz(pred_a);
         end
         FN_ORA: begin
            pred_a = pred_a | opd;
            flag_nz(pred_a);
         end
         FN_LDA: begin
            pred_a = opd;
            flag_nz(pred_a);
         end
         FN_LDX: begin
            pred_x = opd;
            flag_nz(pred_x);
         end
         FN_LDY: begin
            pred_y = opd;
            flag_nz(pred_y);
         end
         FN_SBC: add_carry(~opd);
         FN_STA: begin
            we = 1'b1;
            wd = pred_a;
         end
         FN_STX: begin
            we = 1'b1;
            wd = pred_x;
         end
         FN_STY: begin
            we = 1'b1;
            wd = pred_y;
         end
         FN_TAX: begin
            pred_x = pred_a;
            flag_nz(pred_x);
         end
         FN_TAY: begin
            pred_y = pred_a;
            flag_nz(pred_y);
         end
         FN_TSX: begin
            pred_x = pred_sp;
            flag_nz(pred_x);
         end
         FN_TXA: begin
            pred_a = pred_x;
            flag_nz(pred_a);
         end
         FN_TXS: pred_sp = pred_x;
         FN_TYA: begin
            pred_a = pred_y;
            flag_nz(pred_a);
         end
         FN_ALR: pred_a = shift_rot(SH_LSR, pred_a & opd);
         FN_ANC: begin
            pred_a = pred_a & opd;
            flag_nz(pred_a);
            pred_p[FLAG_C] = pred_a[7];
         end
         FN_ARR: pred_a = shift_rot(SH_ROR, pred_a & opd);
         FN_AXS: begin
            ax = pred_a & pred_x;
            pred_p[FLAG_C] = (ax >= opd);
            pred_x = ax - opd;
            flag_nz(pred_x);
         end
         FN_DCP: begin
            we = 1'b1;
            wd = opd - 8'd1;
            compare_to(pred_a, wd);
         end
         FN_ISC: begin
            we = 1'b1;
            wd = opd + 8'd1;
            add_carry(~wd);
         end
         FN_LAS: begin
            pred_sp = pred_sp & opd;
            pred_a = pred_sp;
            pred_x = pred_sp;
            flag_nz(pred_sp);
         end
         FN_LAX: begin
            pred_a = opd;
            pred_x = opd;
            flag_nz(opd);
         end
         FN_RLA: begin
            we = 1'b1;
            wd = shift_rot(SH_ROL, opd);
            pred_a = pred_a & wd;
            flag_nz(pred_a);
         end
         FN_RRA: begin
            we = 1'b1;
            wd = shift_rot(SH_ROR, opd);
            add_carry(wd);
         end
         FN_SAX: begin
            we = 1'b1;
            wd = pred_a & pred_x;
         end
         FN_SLO: begin
            we = 1'b1;
            wd = shift_rot(SH_ASL, opd);
            pred_a = pred_a | wd;
            flag_nz(pred_a);
         end
         FN_SRE: begin
            we = 1'b1;
            wd = shift_rot(SH_LSR, opd);
            pred_a = pred_a ^ wd;
            flag_nz(pred_a);
         end
         FN_TAS: pred_sp = pred_a & pred_x;
         FN_XAA: begin
            pred_a = pred_x & opd;
            flag_nz(pred_a);
         end
         default: ;   // NOP, KIL and the unused code change nothing
      endcase
      res.acc   = pred_a;
      res.x     = pred_x;
      res.y     = pred_y;
      res.sp    = pred_sp;
      res.flags = pred_p;
      res.we    = we;
      res.wd    = wd;
      res.br    = br;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // monitor and model update, sampled at the rising edge
   always @(posedge clock) begin
      exec_rsp_type want;
      exec_req_type beat;
      if (reset) begin
         req_took <= 1'b0;
         pred_a  = 8'h00;
         pred_x  = 8'h00;
         pred_y  = 8'h00;
         pred_sp = SP_RESET;
         pred_p  = STATUS_RESET;
      end else begin
         req_took <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (regs_expected.size() == 0) begin
               $display("%0t: result beat with nothing expected, acc %02h", $time, rsp_acc);
               mismatches++;
            end else begin
               want = regs_expected.pop_front();
               check_field("acc", want.acc, rsp_acc);
               check_field("index_x", want.x, rsp_index_x);
               check_field("index_y", want.y, rsp_index_y);
               check_field("stack_ptr", want.sp, rsp_stack_ptr);
               check_field("flags", want.flags, rsp_flags);
               check_field("mem_write_en", {7'd0, want.we}, {7'd0, rsp_mem_write_en});
               check_field("mem_write_data", want.wd, rsp_mem_write_data);
               check_field("branch_taken", {7'd0, want.br}, {7'd0, rsp_branch_taken});
            end
         end
         if (req_valid && req_ready) begin
            beat.func    = req_func;
            beat.operand = req_operand;
            beat.to_acc  = req_to_accumulator;
            regs_expected.push_back(execute_op(beat));
            items_accepted++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      exec_req_type beat;
      if (!req_valid || req_took) begin
         if (!reset && ops_to_issue.size() != 0 && $urandom_range(99) >= send_idle) begin
            beat = ops_to_issue.pop_front();
            req_valid <= 1'b1;
            req_func <= beat.func;
            req_operand <= beat.operand;
            req_to_accumulator <= beat.to_acc;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off on request
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_go && !stall_done) begin
         stall_left <= LONG_STALL;
         stall_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout, %0d results still expected", $time, regs_expected.size());
      $display("TEST FAILED");
      $finish;
   end

   task automatic issue(input logic [5:0] f, input logic [7:0] opd, input logic to_acc);
      exec_req_type beat;
      beat.func = f;
      beat.operand = opd;
      beat.to_acc = to_acc;
      ops_to_issue.push_back(beat);
      items_queued++;
   endtask

   task automatic issue_random(input int count);
      logic [7:0] edges[5];
      logic [7:0] opd;
      edges = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
      repeat (count) begin
         if ($urandom_range(3) == 0) opd = edges[3'($urandom_range(4))];
         else opd = 8'($urandom_range(255));
         issue(6'($urandom_range(63)), opd, 1'($urandom_range(1)));
      end
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || regs_expected.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      send_idle = 28;
      recv_idle = 66;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: flag edges, carry and overflow, wraps, shifts both ways, odd opcodes
      issue(FN_LDA, 8'h80, 1'b0);
      issue(FN_LDA, 8'h00, 1'b0);
      issue(FN_SEC, 8'h00, 1'b0);
      issue(FN_ADC, 8'h7F, 1'b0);
      issue(FN_ADC, 8'hFF, 1'b1);
      issue(FN_BVS, 8'h00, 1'b0);
      issue(FN_SBC, 8'hFF, 1'b0);
      issue(FN_BCC, 8'h00, 1'b0);
      issue(FN_CLV, 8'h00, 1'b0);
      issue(FN_BVC, 8'h00, 1'b0);
      issue(FN_ASL, 8'hFF, 1'b1);
      issue(FN_ROR, 8'h01, 1'b0);
      issue(FN_ROL, 8'h00, 1'b1);
      issue(FN_LSR, 8'hFF, 1'b0);
      issue(FN_LDX, 8'hFF, 1'b0);
      issue(FN_INX, 8'h00, 1'b0);
      issue(FN_DEY, 8'h00, 1'b0);
      issue(FN_TXS, 8'h00, 1'b0);
      issue(FN_LAS, 8'hF0, 1'b0);
      issue(FN_LDA, 8'hC1, 1'b0);
      issue(FN_ANC, 8'hFF, 1'b0);
      issue(FN_ARR, 8'hFF, 1'b0);
      issue(FN_AXS, 8'h01, 1'b0);
      issue(FN_ISC, 8'hFF, 1'b0);
      issue(FN_KIL, 8'hFF, 1'b1);
      issue(FN_UNUSED, 8'h55, 1'b1);
      issue(FN_TAS, 8'h00, 1'b0);
      issue(FN_XAA, 8'hFF, 1'b0);
      wait_drained();

      issue_random(RANDOM_OPS);
      stall_go <= 1'b1;
      wait_drained();

      send_idle = 66;
      recv_idle = 28;
      issue_random(RANDOM_OPS);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      issue_random(RANDOM_OPS);
      wait_drained();

      repeat (4) @(negedge clock);
      if (mismatches == 0 && regs_expected.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

@@ byte_cpu_alu_register_execute_top.f @@
+incdir+rtl
rtl/bcpu_pkg.sv
rtl/bcpu_alu.sv
rtl/byte_cpu_alu_register_execute_top.sv
dv/byte_cpu_alu_register_execute_top_test.sv
